// ----- rtl/core/largest_empty_square_finder_core_assert.svh -----
// ----------------------------------------------------------------------------
// largest empty square finder: assertion macros
// shared concurrent assertion forms, clocked on clk; LES_ASSERT is held off in reset
// ----------------------------------------------------------------------------
`ifndef LARGEST_EMPTY_SQUARE_FINDER_CORE_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_CORE_ASSERT_SVH

// assertion sampled on clk, disabled while arst_n is low
`define LES_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assertion sampled on clk at every edge, reset included
`define LES_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/les_pkg.sv -----
// ----------------------------------------------------------------------------
// les_pkg
// shared widths, limits, types and helpers of the largest empty square finder
// ----------------------------------------------------------------------------
package les_pkg;

	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int POS_LIMIT = 1024;
	localparam int COL_CAP   = (MAX_COLS < POS_LIMIT) ? MAX_COLS : POS_LIMIT;
	localparam int ROW_CAP   = ((MAX_ROWS < POS_LIMIT) ? MAX_ROWS : POS_LIMIT) - 1;

	localparam int COL_W   = (COL_CAP > 1) ? $clog2(COL_CAP) : 1;
	localparam int ROW_W   = 10;
	localparam int POS_W   = 10;
	localparam int SIDE_W  = 11;
	localparam int WIDTH_W = 11;

	localparam logic [SIDE_W-1:0]  SIDE_MAX = {SIDE_W{1'b1}};
	localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(COL_CAP);
	localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROW_CAP);

	typedef logic [COL_W-1:0]   col_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [SIDE_W-1:0]  side_t;
	typedef logic [WIDTH_W-1:0] width_t;

	typedef struct packed {
		row_t row;
		col_t col;
	} cell_pos_t;

	typedef struct packed {
		side_t             cell_square;
		side_t             best_size;
		logic [POS_W-1:0]  best_row;
		logic [POS_W-1:0]  best_col;
	} cell_res_t;

	typedef struct packed {
		logic      obstacle;
		logic      last_cell;
		logic      fwd_hit;
		cell_pos_t pos;
	} cell_item_t;

	function automatic width_t eff_width(input width_t w);
		width_t r;
		r = w;
		if (r == '0)
			r = width_t'(1);
		if (r > WIDTH_CAP)
			r = WIDTH_CAP;
		return r;
	endfunction

	function automatic row_t row_step(input row_t r);
		row_t n;
		n = r;
		if (r < ROW_LAST)
			n = r + row_t'(1);
		return n;
	endfunction

endpackage

// ----- rtl/core/largest_empty_square_finder_core.sv -----
// a cell is registered in item_s1 and its result in res_q before the result is offered
// throughput: one cell per cycle unless the output stalls, limited by the line buffer's single read port
// a cell is taken while the previous result still waits at the output
// reset: arst_n clears position counters, neighbor and best state, row_width to 1
// the line buffer is not cleared; entries are read only after the row above wrote them
// ----------------------------------------------------------------------------
// largest_empty_square_finder_core
// streaming maximal-square finder over a row-major grid with a line buffer
// ----------------------------------------------------------------------------
`include "largest_empty_square_finder_core_assert.svh"

module largest_empty_square_finder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,     // row_width
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // obstacle, zero pad
	input  logic        s_axis_tlast,    // last_cell
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,    // cell_square, best_size, best_row, best_col, zero pad
	output logic        m_axis_tlast     // grid_done
);
	import les_pkg::*;

	width_t     row_width_q;
	logic       in_acc;
	logic       valid_s1;
	logic       adv_s1;
	cell_item_t item_s1;
	cell_pos_t  pos;
	side_t      up_rd;
	side_t      cell_side;
	cell_res_t  res;
	cell_res_t  res_q;
	logic       last_q;
	logic       fwd_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_width_q <= width_t'(1);
		else if (cfg_wr_en)
			row_width_q <= cfg_wr_data;
	end

	assign adv_s1        = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign fwd_hit       = adv_s1 && (item_s1.pos.col == pos.col);

	les_addr_gen u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.last_cell (s_axis_tlast),
		.row_width (row_width_q),
		.pos       (pos)
	);

	les_line_buf u_buf (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (pos.col),
		.rd_data (up_rd),
		.wr_en   (adv_s1),
		.wr_addr (item_s1.pos.col),
		.wr_data (cell_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.obstacle  <= s_axis_tdata[0];
			item_s1.last_cell <= s_axis_tlast;
			item_s1.fwd_hit   <= fwd_hit;
			item_s1.pos       <= pos;
		end
	end

	les_cell_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s1),
		.item      (item_s1),
		.up_mem    (up_rd),
		.cell_side (cell_side),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q  <= res;
			last_q <= item_s1.last_cell;
		end
	end

	assign m_axis_tdata = {6'b0, res_q.best_col, res_q.best_row, res_q.best_size,
		res_q.cell_square};
	assign m_axis_tlast = last_q;

	`LES_ASSERT(a_s1_hold, valid_s1 && !adv_s1 |=> valid_s1 && $stable(item_s1), "stalled cell lost")
	`LES_ASSERT(a_best_ge, m_axis_tvalid |-> res_q.cell_square <= res_q.best_size, "best below cell")
	`LES_ASSERT_ALWAYS(a_rdy_empty, !valid_s1 |-> s_axis_tready, "input blocked while stage empty")

endmodule

// ----- rtl/core/les_addr_gen.sv -----
// ----------------------------------------------------------------------------
// les_addr_gen
// row and column position of each incoming cell, wraps columns, saturates rows, restarts after the last cell
// ----------------------------------------------------------------------------
module les_addr_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               last_cell,
	input  les_pkg::width_t    row_width,
	output les_pkg::cell_pos_t pos
);
	import les_pkg::*;

	width_t w;
	col_t   col_q;
	row_t   row_q;
	width_t next_col;

	always_comb begin
		w = eff_width(row_width);
		if (width_t'(col_q) >= w) begin
			pos.col = '0;
			pos.row = row_step(row_q);
		end else begin
			pos.col = col_q;
			pos.row = row_q;
		end
		next_col = width_t'(pos.col) + width_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_cell) begin
				col_q <= '0;
				row_q <= '0;
			end else if (next_col >= w) begin
				col_q <= '0;
				row_q <= row_step(pos.row);
			end else begin
				col_q <= next_col[COL_W-1:0];
				row_q <= pos.row;
			end
		end
	end

endmodule

// ----- rtl/core/les_line_buf.sv -----
// ----------------------------------------------------------------------------
// les_line_buf
// previous-row line buffer, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module les_line_buf (
	input  logic           clk,
	input  logic           rd_en,
	input  les_pkg::col_t  rd_addr,
	output les_pkg::side_t rd_data,
	input  logic           wr_en,
	input  les_pkg::col_t  wr_addr,
	input  les_pkg::side_t wr_data
);
	import les_pkg::*;

	side_t mem [COL_CAP];
	side_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/core/les_cell_calc.sv -----
// ----------------------------------------------------------------------------
// les_cell_calc
// min-of-three square update with neighbor state and best-square tracking
// ----------------------------------------------------------------------------
module les_cell_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  les_pkg::cell_item_t item,
	input  les_pkg::side_t      up_mem,
	output les_pkg::side_t      cell_side,
	output les_pkg::cell_res_t  res
);
	import les_pkg::*;

	side_t left_q;
	side_t ul_q;
	side_t best_q;
	row_t  best_row_q;
	col_t  best_col_q;

	side_t up;
	side_t m;
	side_t v;
	logic  better;

	always_comb begin
		up = item.fwd_hit ? left_q : up_mem;
		m  = left_q;
		if (up < m)
			m = up;
		if (ul_q < m)
			m = ul_q;
		if (item.obstacle)
			v = '0;
		else if (item.pos.row == '0 || item.pos.col == '0)
			v = side_t'(1);
		else if (m == SIDE_MAX)
			v = SIDE_MAX;
		else
			v = m + side_t'(1);
		better = v > best_q;

		res.cell_square = v;
		if (better) begin
			res.best_size = v;
			res.best_row  = POS_W'(item.pos.row);
			res.best_col  = POS_W'(item.pos.col);
		end else begin
			res.best_size = best_q;
			res.best_row  = POS_W'(best_row_q);
			res.best_col  = POS_W'(best_col_q);
		end
	end

	assign cell_side = v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			ul_q       <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (adv) begin
			if (item.last_cell) begin
				left_q     <= '0;
				ul_q       <= '0;
				best_q     <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
			end else begin
				left_q <= v;
				ul_q   <= up;
				if (better) begin
					best_q     <= v;
					best_row_q <= item.pos.row;
					best_col_q <= item.pos.col;
				end
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: largest empty square finder core testbench
// drives row-major grid cells through the input stream and predicts, for every
// cell, the largest empty square ending there plus the running best square;
// results are checked in order while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import les_pkg::*;

	localparam int HOLD_CYCLES = 64;

	typedef struct packed {
		side_t      cell_square;
		side_t      best_size;
		logic [9:0] best_row;
		logic [9:0] best_col;
		logic       grid_done;
	} square_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;    // obstacle, zero pad
	logic        s_axis_tlast;    // last_cell
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;    // cell_square, best_size, best_row, best_col, zero pad
	logic        m_axis_tlast;    // grid_done

	// predictor state
	int line_buf[COL_CAP];
	int left_side;
	int diag_side;
	int col_at;
	int row_at;
	int best_side;
	int best_row_at;
	int best_col_at;
	int row_width_cfg = 1;

	square_res_t squares_due[$];
	int          errors;
	bit          tx_quiet;
	bit          rx_quiet;
	bit          hold_req;

	largest_empty_square_finder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("largest_empty_square_finder_core: mismatch");
		$finish;
	end

	function automatic void advance_row();
		col_at = 0;
		if (row_at < ROW_LAST)
			row_at++;
	endfunction

	function automatic void clear_grid();
		left_side   = 0;
		diag_side   = 0;
		col_at      = 0;
		row_at      = 0;
		best_side   = 0;
		best_row_at = 0;
		best_col_at = 0;
	endfunction

	function automatic square_res_t compute_square(input logic obst, input logic last);
		int          w;
		int          up;
		int          v;
		square_res_t r;
		w = (row_width_cfg == 0) ? 1 : row_width_cfg;
		if (w > COL_CAP)
			w = COL_CAP;
		if (col_at >= w)
			advance_row();
		up = line_buf[col_at];
		if (obst) begin
			v = 0;
		end else if (row_at == 0 || col_at == 0) begin
			v = 1;
		end else begin
			v = left_side;
			if (up < v)
				v = up;
			if (diag_side < v)
				v = diag_side;
			v++;
			if (v > SIDE_MAX)
				v = SIDE_MAX;
		end
		diag_side       = up;
		left_side       = v;
		line_buf[col_at] = v;
		if (v > best_side) begin
			best_side   = v;
			best_row_at = row_at;
			best_col_at = col_at;
		end
		r.cell_square = side_t'(v);
		r.best_size   = side_t'(best_side);
		r.best_row    = 10'(best_row_at);
		r.best_col    = 10'(best_col_at);
		r.grid_done   = last;
		if (last) begin
			clear_grid();
		end else begin
			col_at++;
			if (col_at >= w)
				advance_row();
		end
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [10:0] want,
			input logic [10:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
			errors++;
		end
	endtask

	// output side: stall per result, long hold on request
	initial begin : result_sink
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		square_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (squares_due.size() == 0) begin
				$display("%0t ns: unexpected transfer, expected none, got data %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = squares_due.pop_front();
				check_field("cell_square", want.cell_square, m_axis_tdata[10:0]);
				check_field("best_size", want.best_size, m_axis_tdata[21:11]);
				check_field("best_row", 11'(want.best_row), 11'(m_axis_tdata[31:22]));
				check_field("best_col", 11'(want.best_col), 11'(m_axis_tdata[41:32]));
				check_field("grid_done", 11'(want.grid_done), 11'(m_axis_tlast));
			end
		end
	end

	task automatic send_cell(input logic obst, input logic last);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, obst};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		squares_due.push_back(compute_square(obst, last));
	endtask

	task automatic send_grid(input int cells, input int obst_pct);
		for (int i = 0; i < cells; i++)
			send_cell($urandom_range(0, 99) < obst_pct, i == cells - 1);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (squares_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_width(input logic [10:0] w);
		settle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		row_width_cfg = w;
	endtask

	// width 1 from reset: every cell opens a row
	task automatic test_reset_width();
		send_cell(1'b1, 1'b0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b0, 1'b1);
	endtask

	task automatic test_width_zero();
		write_width(11'd0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b0, 1'b0);
		send_cell(1'b1, 1'b1);
	endtask

	// first row and column count, square of two, ties keep the first
	task automatic test_square_growth_and_ties();
		logic [11:0] pattern;
		pattern = 12'b0001_0000_0010;
		write_width(11'd4);
		for (int i = 0; i < 12; i++)
			send_cell(pattern[i], i == 11);
	endtask

	task automatic test_width_shrink_mid_row();
		write_width(11'd6);
		for (int i = 0; i < 4; i++)
			send_cell(1'b0, 1'b0);
		write_width(11'd3);
		for (int i = 0; i < 4; i++)
			send_cell(1'b0, i == 3);
	endtask

	task automatic test_output_stall();
		write_width(11'd5);
		hold_req = 1'b1;
		tx_quiet = 1'b1;
		send_grid(40, 20);
		tx_quiet = 1'b0;
	endtask

	task automatic test_wide_rows();
		write_width(11'd1024);
		send_grid(6, 30);
		write_width(11'd1025);
		send_grid(6, 15);
		write_width(11'd2047);
		send_grid(6, 10);
	endtask

	task automatic test_random_grids();
		int          sent;
		int          rows;
		int          cells;
		int          pct;
		int          eff;
		logic [10:0] w;
		sent = 0;
		w    = 11'd4;
		while (sent < 366) begin
			if (sent == 0 || $urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0: w = 11'd0;
					1, 2: w = 11'($urandom_range(11, 48));
					default: w = 11'($urandom_range(1, 10));
				endcase
				write_width(w);
			end
			eff   = (w == 0) ? 1 : w;
			rows  = (eff > 10) ? $urandom_range(1, 3) : $urandom_range(1, 10);
			cells = eff * rows + (($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : 0);
			if ($urandom_range(0, 9) == 0)
				cells = $urandom_range(1, cells);
			case ($urandom_range(0, 4))
				0: pct = 0;
				1: pct = 5;
				2: pct = 20;
				3: pct = 50;
				default: pct = 85;
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			send_grid(cells, pct);
			sent += cells;
		end
		tx_quiet = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		errors        = 0;
		tx_quiet      = 1'b0;
		rx_quiet      = 1'b0;
		hold_req      = 1'b0;
		clear_grid();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_width();
		test_width_zero();
		test_square_growth_and_ties();
		test_width_shrink_mid_row();
		test_output_stall();
		test_wide_rows();
		test_random_grids();

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && squares_due.size() == 0)
			$display("largest_empty_square_finder_core: match");
		else
			$display("largest_empty_square_finder_core: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/les_pkg.sv
rtl/core/les_addr_gen.sv
rtl/core/les_line_buf.sv
rtl/core/les_cell_calc.sv
rtl/core/largest_empty_square_finder_core.sv
tb/tb_top.sv
